/* design/pbsp_pkg.sv */
// Shared types, section and status codes for the protected blob stream parser.
// Used by pbsp_step, pbsp_out_buf and protected_blob_stream_parser_core.
package pbsp_pkg;

  localparam int unsigned WordBytes = 4;
  localparam int unsigned IdBytes   = 16;

  // section codes
  localparam logic [4:0] SEC_OUTER_VER     = 5'd0;
  localparam logic [4:0] SEC_PROVIDER_ID   = 5'd1;
  localparam logic [4:0] SEC_INNER_VER     = 5'd2;
  localparam logic [4:0] SEC_MASTER_KEY_ID = 5'd3;
  localparam logic [4:0] SEC_DESC_LEN      = 5'd5;
  localparam logic [4:0] SEC_DESC          = 5'd6;
  localparam logic [4:0] SEC_SALT          = 5'd10;
  localparam logic [4:0] SEC_KEY           = 5'd12;
  localparam logic [4:0] SEC_MAC_SALT      = 5'd16;
  localparam logic [4:0] SEC_CIPHER        = 5'd18;
  localparam logic [4:0] SEC_MAC_FIRST     = 5'd2;
  localparam logic [4:0] SEC_MAC_LAST      = 5'd18;
  localparam logic [4:0] SEC_SIGNATURE     = 5'd20;
  localparam logic [4:0] SEC_DONE          = 5'd21;

  // section kinds
  localparam logic [1:0] KIND_WORD = 2'd0;
  localparam logic [1:0] KIND_ID   = 2'd1;
  localparam logic [1:0] KIND_VAR  = 2'd2;

  // status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_BAD_VER   = 3'd2;
  localparam logic [2:0] ST_ODD_DESC  = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_TRAILING  = 3'd5;

  localparam logic [31:0] EXPECTED_VERSION_RESET = 32'd1;

  typedef struct packed {
    logic [4:0]  section;
    logic [7:0]  byte_out;
    logic        in_mac_prefix;
    logic        word_done;
    logic [31:0] word_value;
    logic        blob_end;
    logic [2:0]  status;
  } result_t;

  function automatic logic [1:0] sec_kind(input logic [4:0] sec);
    logic [1:0] kind;
    unique case (sec) inside
      SEC_PROVIDER_ID, SEC_MASTER_KEY_ID: kind = KIND_ID;
      SEC_DESC, SEC_SALT, SEC_KEY, SEC_MAC_SALT, SEC_CIPHER, SEC_SIGNATURE:
        kind = KIND_VAR;
      default: kind = KIND_WORD;
    endcase
    return kind;
  endfunction

endpackage

/* design/pbsp_step.sv */
// Parse state registers and per-byte next-state logic of the blob parser.
// Depends on pbsp_pkg for section kinds, codes and the result struct.
module pbsp_step
  import pbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output result_t     result
);

  logic [31:0] expected_version;
  logic [4:0]  phase, phase_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] word_shift, word_shift_next;
  logic [2:0]  error_code, error_code_next;

  logic [1:0]  kind, kind_nx;
  logic [1:0]  pos;
  logic [31:0] word_acc;
  logic [4:0]  phase_p1, phase_p2;
  logic        skip;

  always_comb begin
    kind     = sec_kind(phase);
    phase_p1 = 5'(phase + 5'd1);
    phase_p2 = 5'(phase + 5'd2);
    kind_nx  = sec_kind(phase_p1);
    // byte position inside the word: 4 left -> 0, 1 left -> 3
    pos      = 2'(2'd0 - bytes_left[1:0]);
    word_acc = word_shift;
    word_acc[{pos, 3'b000} +: 8] = word_shift[{pos, 3'b000} +: 8] | data_byte;
    skip     = 1'b0;

    phase_next      = phase;
    bytes_left_next = bytes_left;
    word_shift_next = word_shift;
    error_code_next = error_code;

    result.section       = SEC_DONE;
    result.byte_out      = data_byte;
    result.in_mac_prefix = 1'b0;
    result.word_done     = 1'b0;
    result.word_value    = '0;
    result.blob_end      = is_last;

    if (error_code != ST_BUSY || phase >= SEC_DONE) begin
      if (error_code == ST_BUSY) begin
        error_code_next = ST_TRAILING;
      end
    end else begin
      result.section       = phase;
      result.in_mac_prefix = (phase >= SEC_MAC_FIRST) && (phase <= SEC_MAC_LAST);
      if (bytes_left != 32'd1) begin
        bytes_left_next = bytes_left - 32'd1;
        if (kind == KIND_WORD) begin
          word_shift_next = word_acc;
        end
      end else if (kind == KIND_WORD) begin
        word_shift_next   = '0;
        result.word_done  = 1'b1;
        result.word_value = word_acc;
        if ((phase == SEC_OUTER_VER || phase == SEC_INNER_VER) &&
            word_acc != expected_version) begin
          error_code_next = ST_BAD_VER;
        end else if (phase == SEC_DESC_LEN && word_acc[0]) begin
          error_code_next = ST_ODD_DESC;
        end
        phase_next = phase_p1;
        case (kind_nx)
          KIND_ID:  bytes_left_next = 32'(IdBytes);
          KIND_VAR: begin
            if (word_acc != '0) begin
              bytes_left_next = word_acc;
            end else begin
              skip = 1'b1;
            end
          end
          default:  bytes_left_next = 32'(WordBytes);
        endcase
        // empty variable section: jump over it
        if (skip) begin
          if (phase_p1 == SEC_SIGNATURE) begin
            phase_next      = SEC_DONE;
            bytes_left_next = '0;
          end else begin
            phase_next      = phase_p2;
            bytes_left_next = 32'(WordBytes);
          end
        end
      end else begin
        // id or variable section finished; a word section or the end follows
        if (phase == SEC_SIGNATURE) begin
          phase_next      = SEC_DONE;
          bytes_left_next = '0;
        end else begin
          phase_next      = phase_p1;
          bytes_left_next = 32'(WordBytes);
        end
      end
    end

    if (error_code_next != ST_BUSY) begin
      result.status = error_code_next;
    end else if (is_last) begin
      result.status = (phase_next == SEC_DONE) ? ST_OK : ST_TRUNC;
    end else begin
      result.status = ST_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= EXPECTED_VERSION_RESET;
    end else if (cfg_we) begin
      expected_version <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= SEC_OUTER_VER;
      bytes_left <= 32'(WordBytes);
      word_shift <= '0;
      error_code <= ST_BUSY;
    end else if (accept) begin
      if (is_last) begin
        // restart for the next blob
        phase      <= SEC_OUTER_VER;
        bytes_left <= 32'(WordBytes);
        word_shift <= '0;
        error_code <= ST_BUSY;
      end else begin
        phase      <= phase_next;
        bytes_left <= bytes_left_next;
        word_shift <= word_shift_next;
        error_code <= error_code_next;
      end
    end
  end

endmodule

/* design/pbsp_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
// Depends on pbsp_pkg for the result struct.
module pbsp_out_buf
  import pbsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    space,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    head_valid, skid_valid;
  result_t head, skid;
  logic    pop;

  assign space     = !skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;
  assign pop       = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!head_valid || pop) begin
      head_valid <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
  end

endmodule

/* design/protected_blob_stream_parser_core.sv */
// Top level of the protected blob stream parser.
// Depends on pbsp_pkg, pbsp_step and pbsp_out_buf.
//
// Takes one blob byte per cycle while in_ready is high and returns one tagged
// result per byte, registered in the output buffer. Throughput is one byte every
// cycle while in_ready is high: the parse state (section, bytes left, partial word,
// sticky error) updates once per byte, and a two-entry output buffer lets in_ready
// stay high while one result waits; in_ready drops only while both entries are held.
// A byte carrying is_last restarts the parse for the next blob.
// expected_version is written through the cfg channel, which is always ready;
// write it only while no byte is in flight.
module protected_blob_stream_parser_core
  import pbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  section,
  output logic [7:0]  byte_out,
  output logic        in_mac_prefix,
  output logic        word_done,
  output logic [31:0] word_value,
  output logic        blob_end,
  output logic [2:0]  status
);

  logic    accept;
  result_t step_result, out_data;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  pbsp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (data_byte),
    .is_last   (is_last),
    .result    (step_result)
  );

  pbsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign section       = out_data.section;
  assign byte_out      = out_data.byte_out;
  assign in_mac_prefix = out_data.in_mac_prefix;
  assign word_done     = out_data.word_done;
  assign word_value    = out_data.word_value;
  assign blob_end      = out_data.blob_end;
  assign status        = out_data.status;

  // discarded bytes always carry an error
  a_discard_has_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && section == SEC_DONE |-> status != ST_BUSY)
    else $error("discarded byte without error status");

  // completed and truncated only on the last byte
  a_final_status_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK || status == ST_TRUNC) |-> blob_end)
    else $error("final status on a byte without last mark");

  a_word_not_discarded: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_done |-> section != SEC_DONE)
    else $error("word reported on discarded byte");

  a_mac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_mac_prefix |-> section >= SEC_MAC_FIRST && section <= SEC_MAC_LAST)
    else $error("mac prefix flag outside authenticated sections");

endmodule
